FILE: hdl/lbap_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the bus address programmer.
// No dependencies; every other file imports this package.
package lbap_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOGIN_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK = 2'd3;

  localparam logic [7:0] POWER_UP_RESET = 8'd10;
  localparam logic [4:0] LOGIN_TIMEOUT_RESET = 5'd15;
  localparam logic [7:0] SHOW_RESET = 8'd20;
  localparam logic [3:0] BLINK_RESET = 4'd10;

  localparam logic [7:0] ADDR_LOGIN = 8'hFE;
  localparam logic [7:0] ADDR_DTR0 = 8'hA3;
  localparam logic [7:0] ADDR_BCAST_CMD = 8'hFF;
  localparam logic [7:0] CMD_STORE_SHORT = 8'h80;
  localparam logic [7:0] CMD_QUERY_LEVEL = 8'hA0;
  localparam logic [7:0] RX_NO_ANSWER = 8'hFF;
  localparam logic [7:0] LOGIN_REPLY = 8'h50;
  localparam logic [7:0] MAX_ADDR = 8'd63;

  localparam logic [5:0] LED_OFF = 6'h00;
  localparam logic [5:0] LED_ERROR = 6'h01;
  localparam logic [5:0] LED_BUSY = 6'h02;
  localparam logic [5:0] LED_STORED = 6'h04;
  localparam logic [5:0] LED_CHECK_FAIL = 6'h08;
  localparam logic [5:0] LED_CHECKING = 6'h10;
  localparam logic [5:0] LED_CHECK_OK = 6'h20;

  localparam logic [2:0] LOGIN_LEN = 3'd5;
  localparam logic [2:0] LOGIN_WAITING = 3'd6;
  localparam logic [2:0] LOGIN_TIMED_OUT = 3'd7;

  localparam logic [2:0] DIM_LAST = 3'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_ONE,
    JOB_STORE,
    JOB_DIM
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [5:0] led;
    logic       relay;
  } job_t;

  function automatic logic [7:0] login_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = 8'h50;
      3'd1: c = 8'h41;
      3'd2: c = 8'h52;
      3'd3: c = 8'h41;
      3'd4: c = 8'h4D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] dim_level(input logic [2:0] idx);
    logic [7:0] l;
    unique case (idx)
      3'd0: l = 8'd254;
      3'd1: l = 8'd243;
      3'd2: l = 8'd230;
      3'd3: l = 8'd203;
      3'd4: l = 8'd180;
      3'd5: l = 8'd144;
      default: l = 8'd0;
    endcase
    return l;
  endfunction

endpackage

FILE: hdl/lbap_if.sv
`timescale 1ns / 1ps
// Channel interfaces: tick input, configuration write, result output.
// Depends on lbap_pkg.
interface lbap_tick_if;
  logic       valid;
  logic       ready;
  logic       start_button;
  logic       check_button;
  logic [3:0] tens_switch_raw;
  logic [3:0] ones_switch_raw;
  logic       rx_valid;
  logic [7:0] rx_byte;

  modport source(output valid, start_button, check_button, tens_switch_raw,
                 ones_switch_raw, rx_valid, rx_byte, input ready);
  modport sink(input valid, start_button, check_button, tens_switch_raw,
               ones_switch_raw, rx_valid, rx_byte, output ready);
endinterface

interface lbap_cfg_if import lbap_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface lbap_result_if;
  logic       valid;
  logic       ready;
  logic       frame_valid;
  logic [7:0] frame_address;
  logic [7:0] frame_command;
  logic [5:0] led_pattern;
  logic       relay_on;
  logic       last_result;

  modport source(output valid, frame_valid, frame_address, frame_command,
                 led_pattern, relay_on, last_result, input ready);
  modport sink(input valid, frame_valid, frame_address, frame_command,
               led_pattern, relay_on, last_result, output ready);
endinterface

FILE: hdl/lbap_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers and the programming sequencer; turns each
// tick into one emission job. Depends on lbap_pkg and lbap_if.
module lbap_front import lbap_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  lbap_tick_if.sink    tick,
  lbap_cfg_if.sink     cfg,
  output job_t         job,
  output logic         job_valid,
  input  logic         job_ready
);

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_POWER = 4'd1,
    M_LOGIN = 4'd2,
    M_FAIL  = 4'd3,
    M_DTR   = 4'd4,
    M_STORE = 4'd5,
    M_SHOW  = 4'd6,
    M_CHECK = 4'd7,
    M_QUERY = 4'd8,
    M_DIM   = 4'd9
  } mode_t;

  logic [7:0] power_up_ticks;
  logic [4:0] login_timeout_ticks;
  logic [7:0] show_ticks;
  logic [3:0] blink_period;

  mode_t      mode, mode_next;
  logic [7:0] step_count, step_count_next;
  logic [2:0] login_index, login_index_next;
  logic [4:0] login_wait, login_wait_next;
  logic [3:0] blink_count, blink_count_next;
  logic [7:0] reply_byte, reply_byte_next;
  logic [5:0] led_state, led_state_next;
  logic       relay_state, relay_state_next;

  logic [3:0] tens, ones;
  logic [7:0] addr;
  logic [3:0] blink_inc;
  logic [7:0] step_inc;
  logic       accept;
  job_t       job_next;

  assign cfg.ready = 1'b1;
  assign tick.ready = job_ready;
  assign job_valid = tick.valid;
  assign accept = tick.valid & job_ready;
  assign job = job_next;

  assign tens = ~tick.tens_switch_raw;
  assign ones = ~tick.ones_switch_raw;
  assign addr = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'b0000, ones};
  assign blink_inc = blink_count + 4'd1;
  assign step_inc = step_count + 8'd1;

  always_comb begin
    mode_next = mode;
    step_count_next = step_count;
    login_index_next = login_index;
    login_wait_next = login_wait;
    blink_count_next = (blink_inc >= blink_period) ? 4'd0 : blink_inc;
    reply_byte_next = tick.rx_valid ? tick.rx_byte : reply_byte;
    led_state_next = led_state;
    relay_state_next = relay_state;
    job_next.kind = JOB_NONE;
    job_next.addr = 8'h00;
    job_next.cmd = 8'h00;
    if (addr > MAX_ADDR) begin
      led_state_next = (blink_count_next < (blink_period >> 1)) ? LED_ERROR : LED_OFF;
      relay_state_next = 1'b0;
      mode_next = M_IDLE;
    end else begin
      unique case (mode)
        M_IDLE: begin
          relay_state_next = 1'b0;
          led_state_next = (blink_count_next == 4'd1) ? LED_BUSY : LED_OFF;
          login_wait_next = 5'd0;
          login_index_next = 3'd0;
          reply_byte_next = 8'h00;
          step_count_next = 8'd0;
          if (tick.check_button) mode_next = M_CHECK;
          else if (tick.start_button) mode_next = M_POWER;
        end
        M_POWER: begin
          led_state_next = LED_OFF;
          relay_state_next = 1'b1;
          step_count_next = step_inc;
          if (step_inc >= power_up_ticks) begin
            step_count_next = 8'd0;
            login_index_next = 3'd0;
            reply_byte_next = 8'h00;
            login_wait_next = 5'd0;
            mode_next = M_LOGIN;
          end
        end
        M_LOGIN: begin
          if (login_index < LOGIN_LEN) begin
            led_state_next = led_state ^ LED_BUSY;
            job_next.kind = JOB_ONE;
            job_next.addr = ADDR_LOGIN;
            job_next.cmd = login_char(login_index);
            login_index_next = login_index + 3'd1;
          end else begin
            login_index_next = (login_index == LOGIN_LEN) ? LOGIN_WAITING : login_index;
            if (reply_byte_next == LOGIN_REPLY) begin
              reply_byte_next = 8'h00;
              step_count_next = 8'd0;
              mode_next = M_DTR;
            end else if (login_index_next == LOGIN_TIMED_OUT) begin
              step_count_next = 8'd0;
              mode_next = M_FAIL;
            end else if (login_wait >= login_timeout_ticks) begin
              login_index_next = LOGIN_TIMED_OUT;
            end else begin
              login_wait_next = login_wait + 5'd1;
            end
          end
        end
        M_FAIL: begin
          relay_state_next = 1'b1;
          led_state_next = LED_ERROR;
          step_count_next = step_inc;
          if (step_inc >= show_ticks) begin
            step_count_next = 8'd0;
            relay_state_next = 1'b0;
            mode_next = M_IDLE;
          end
        end
        M_DTR: begin
          led_state_next = LED_BUSY;
          job_next.kind = JOB_ONE;
          job_next.addr = ADDR_DTR0;
          job_next.cmd = addr;
          reply_byte_next = 8'h00;
          login_wait_next = 5'd0;
          mode_next = M_STORE;
        end
        M_STORE: begin
          led_state_next = LED_BUSY;
          job_next.kind = JOB_STORE;
          job_next.addr = ADDR_BCAST_CMD;
          job_next.cmd = CMD_STORE_SHORT;
          reply_byte_next = 8'h00;
          step_count_next = 8'd0;
          mode_next = M_SHOW;
        end
        M_SHOW: begin
          led_state_next = LED_STORED;
          step_count_next = step_inc;
          if (step_inc >= show_ticks) begin
            step_count_next = 8'd0;
            relay_state_next = 1'b0;
            led_state_next = LED_OFF;
            mode_next = M_IDLE;
          end
        end
        M_CHECK: begin
          relay_state_next = 1'b1;
          led_state_next = LED_CHECKING;
          job_next.kind = JOB_ONE;
          job_next.addr = {addr[6:0], 1'b1};
          job_next.cmd = CMD_QUERY_LEVEL;
          mode_next = M_QUERY;
        end
        M_QUERY: begin
          if (tick.rx_valid && tick.rx_byte != CMD_QUERY_LEVEL &&
              tick.rx_byte != RX_NO_ANSWER) begin
            reply_byte_next = tick.rx_byte;
            led_state_next = LED_CHECK_OK;
            mode_next = M_DIM;
          end else begin
            reply_byte_next = 8'h00;
            led_state_next = LED_CHECK_FAIL;
            relay_state_next = 1'b0;
            mode_next = M_IDLE;
          end
        end
        M_DIM: begin
          job_next.kind = JOB_DIM;
          job_next.addr = {addr[6:0], 1'b0};
          relay_state_next = 1'b0;
          mode_next = M_IDLE;
        end
        default: begin
          led_state_next = led_state | LED_ERROR;
          mode_next = M_IDLE;
        end
      endcase
    end
    job_next.led = led_state_next;
    job_next.relay = (job_next.kind == JOB_DIM) ? relay_state : relay_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_up_ticks <= POWER_UP_RESET;
      login_timeout_ticks <= LOGIN_TIMEOUT_RESET;
      show_ticks <= SHOW_RESET;
      blink_period <= BLINK_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_POWER_UP: power_up_ticks <= cfg.data;
        CFG_LOGIN_TIMEOUT: login_timeout_ticks <= cfg.data[4:0];
        CFG_SHOW: show_ticks <= cfg.data;
        CFG_BLINK: blink_period <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      step_count <= 8'd0;
      login_index <= 3'd0;
      login_wait <= 5'd0;
      blink_count <= 4'd0;
      reply_byte <= 8'h00;
      led_state <= LED_OFF;
      relay_state <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      step_count <= step_count_next;
      login_index <= login_index_next;
      login_wait <= login_wait_next;
      blink_count <= blink_count_next;
      reply_byte <= reply_byte_next;
      led_state <= led_state_next;
      relay_state <= relay_state_next;
    end
  end

endmodule

FILE: hdl/lbap_queue.sv
`timescale 1ns / 1ps
// Short job queue between the sequencer and the frame emitter.
// Depends on lbap_pkg.
module lbap_queue import lbap_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  job_t push_job,
  input  logic push_valid,
  output logic push_ready,
  output job_t pop_job,
  output logic pop_valid,
  input  logic pop_ready
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_job = mem[rd_ptr];
  assign push = push_valid & push_ready;
  assign pop = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

FILE: hdl/lbap_back.sv
`timescale 1ns / 1ps
// Back end: expands each job into one, two or six result items through a
// registered output stage. Depends on lbap_pkg and lbap_if.
module lbap_back import lbap_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  job_t          job,
  input  logic          job_valid,
  output logic          job_ready,
  lbap_result_if.source result
);

  job_t       cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic       advance;
  logic       is_last;
  logic       fv_next;
  logic [7:0] addr_next;
  logic [7:0] cmd_next;
  logic       relay_next;

  always_comb begin
    fv_next = 1'b1;
    addr_next = cur.addr;
    cmd_next = cur.cmd;
    relay_next = cur.relay;
    unique case (cur.kind)
      JOB_NONE: begin
        fv_next = 1'b0;
        addr_next = 8'h00;
        cmd_next = 8'h00;
        is_last = 1'b1;
      end
      JOB_ONE: is_last = 1'b1;
      JOB_STORE: is_last = (idx == 3'd1);
      JOB_DIM: begin
        cmd_next = dim_level(idx);
        is_last = (idx == DIM_LAST);
        if (is_last) relay_next = 1'b0;
      end
      default: is_last = 1'b1;
    endcase
  end

  assign advance = cur_valid & (~result.valid | result.ready);
  assign job_ready = ~cur_valid | (advance & is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= 3'd0;
      result.valid <= 1'b0;
    end else begin
      if (job_ready) begin
        cur_valid <= job_valid;
        idx <= 3'd0;
      end else if (advance) begin
        idx <= idx + 3'd1;
      end
      if (advance) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready) cur <= job;
    if (advance) begin
      result.frame_valid <= fv_next;
      result.frame_address <= addr_next;
      result.frame_command <= cmd_next;
      result.led_pattern <= cur.led;
      result.relay_on <= relay_next;
      result.last_result <= is_last;
    end
  end

endmodule

FILE: hdl/lighting_bus_address_programmer_unit.sv
`timescale 1ns / 1ps
// Top level of the lighting bus address programmer.
// Depends on lbap_pkg, lbap_if, lbap_front, lbap_queue, lbap_back.
//
//   channel  dir  handshake      payload
//   tick     in   valid/ready    buttons, switch nibbles, received byte
//   cfg      in   valid/ready    index, data (ready always high)
//   result   out  valid/ready    frame, LED pattern, relay, last flag
//
// A tick is accepted whenever the job queue has room (4 jobs).
// Each tick yields 1, 2 or 6 results, one per cycle from the output register while
// result ready is high; the emitter draining the queue sets the sustained rate.
// Synchronous reset restores register defaults and idle state.
// A stalled result blocks the emitter only; ticks keep entering until the queue fills.
module lighting_bus_address_programmer_unit import lbap_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  lbap_tick_if.sink     tick,
  lbap_cfg_if.sink      cfg,
  lbap_result_if.source result
);

  job_t push_job;
  logic push_valid;
  logic push_ready;
  job_t pop_job;
  logic pop_valid;
  logic pop_ready;

  lbap_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .cfg       (cfg),
    .job       (push_job),
    .job_valid (push_valid),
    .job_ready (push_ready)
  );

  lbap_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  lbap_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (pop_job),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .result    (result)
  );

`ifndef SYNTHESIS
  a_non_last_has_frame: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.last_result |-> result.frame_valid)
    else $error("non-final result without a frame");

  a_empty_frame_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.frame_valid |->
      result.frame_address == 8'h00 && result.frame_command == 8'h00)
    else $error("frame bytes set without a frame");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

  a_job_pop_only_when_ready: assert property (@(posedge clk) disable iff (rst)
    pop_valid && pop_ready && pop_job.kind == JOB_DIM |-> ##2 result.valid)
    else $error("dimming job taken without emitting");
`endif

endmodule
